[sv/e2r_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package e2r_pkg;
  localparam int CordicStages = 14;
  localparam int AtanEntries = 24;
  localparam int UsedStages = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
  localparam int AngW = 34;
  localparam int XyW = 33;
  localparam int QW = 22;

  localparam logic signed [AngW-1:0] AngPi = 34'sd1686629713;
  localparam logic signed [AngW-1:0] AngHalfPi = 34'sd843314857;
  localparam logic signed [XyW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [QW-1:0] OneQ20 = 22'sd1048576;

  typedef logic signed [15:0] word_t;
  typedef logic signed [QW-1:0] q20_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t roll_angle;
    word_t pitch_angle;
    word_t yaw_angle;
  } pose_t;

  typedef struct packed {
    word_t m00; word_t m01; word_t m02;
    word_t m10; word_t m11; word_t m12;
    word_t m20; word_t m21; word_t m22;
    word_t out_x; word_t out_y; word_t out_z;
  } rot_t;

  function automatic logic signed [AngW-1:0] atan_at(input int i);
    logic signed [AngW-1:0] r;
    case (i)
      0: r = 34'sd421657428;  1: r = 34'sd248918915;  2: r = 34'sd131521918;
      3: r = 34'sd66762579;   4: r = 34'sd33510843;   5: r = 34'sd16771758;
      6: r = 34'sd8387925;    7: r = 34'sd4194219;    8: r = 34'sd2097141;
      9: r = 34'sd1048575;   10: r = 34'sd524288;    11: r = 34'sd262144;
      12: r = 34'sd131072;   13: r = 34'sd65536;     14: r = 34'sd32768;
      15: r = 34'sd16384;    16: r = 34'sd8192;      17: r = 34'sd4096;
      18: r = 34'sd2048;     19: r = 34'sd1024;      20: r = 34'sd512;
      21: r = 34'sd256;      22: r = 34'sd128;       23: r = 34'sd64;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rounded Q1.20 product.
  function automatic q20_t mul20(input q20_t a, input q20_t b);
    logic signed [2*QW-1:0] p;
    p = a * b + (44'sd1 <<< 19);
    return QW'(p >>> 20);
  endfunction

  // Q1.20 value (possibly grown) to saturated Q2.14.
  function automatic word_t to_q14(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] r;
    r = (v + 24'sd32) >>> 6;
    if (r > 24'sd16384) return 16'sd16384;
    if (r < -24'sd16384) return -16'sd16384;
    return r[15:0];
  endfunction
endpackage
`default_nettype wire

[sv/e2r_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface e2r_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/e2r_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipelined sine/cosine of one angle, one CORDIC iteration per stage.
module e2r_cordic (
  input  wire logic clk,
  input  wire logic en,
  input  wire e2r_pkg::word_t angle,
  output e2r_pkg::q20_t sin_q,
  output e2r_pkg::q20_t cos_q
);
  import e2r_pkg::*;

  logic signed [AngW-1:0] z [UsedStages+1];
  logic signed [XyW-1:0] x [UsedStages+1];
  logic signed [XyW-1:0] y [UsedStages+1];
  logic neg [UsedStages+1];
  logic signed [AngW-1:0] z_in;
  logic signed [XyW-1:0] xo, yo, xr, yr;

  always_comb begin
    z_in = AngW'(angle) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CordicGain;
      y[0] <= '0;
      if (z_in > AngHalfPi) begin
        z[0] <= z_in - AngPi; neg[0] <= 1'b1;
      end else if (z_in < -AngHalfPi) begin
        z[0] <= z_in + AngPi; neg[0] <= 1'b1;
      end else begin
        z[0] <= z_in; neg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < UsedStages; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_at(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_at(i);
        end
      end
    end
  end

  always_comb begin
    xo = neg[UsedStages] ? -x[UsedStages] : x[UsedStages];
    yo = neg[UsedStages] ? -y[UsedStages] : y[UsedStages];
    xr = (xo + 33'sd512) >>> 10;
    yr = (yo + 33'sd512) >>> 10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= (xr > XyW'(OneQ20)) ? OneQ20 : (xr < -XyW'(OneQ20)) ? -OneQ20 : xr[QW-1:0];
      sin_q <= (yr > XyW'(OneQ20)) ? OneQ20 : (yr < -XyW'(OneQ20)) ? -OneQ20 : yr[QW-1:0];
    end
  end
endmodule
`default_nettype wire

[sv/e2r_matrix.sv]
`timescale 1ns / 1ps
`default_nettype none
// Three-stage product and sum pipeline from six Q1.20 terms to nine entries.
module e2r_matrix (
  input  wire logic clk,
  input  wire logic en,
  input  wire e2r_pkg::q20_t sr, cr, sp, cp, sy, cy,
  output e2r_pkg::word_t m [9]
);
  import e2r_pkg::*;

  q20_t t, u, sr1, cr1, sp1, cp1, sy1, cy1;
  q20_t p00, p01a, p01b, p02a, p02b, p10, p11a, p11b, p12a, p12b, p20, p21, p22;

  always_ff @(posedge clk) begin
    if (en) begin
      t <= mul20(sp, sr); u <= mul20(sp, cr);
      sr1 <= sr; cr1 <= cr; sp1 <= sp; cp1 <= cp; sy1 <= sy; cy1 <= cy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= mul20(cy1, cp1);
      p01a <= mul20(cy1, t); p01b <= mul20(sy1, cr1);
      p02a <= mul20(cy1, u); p02b <= mul20(sy1, sr1);
      p10 <= mul20(sy1, cp1);
      p11a <= mul20(sy1, t); p11b <= mul20(cy1, cr1);
      p12a <= mul20(sy1, u); p12b <= mul20(cy1, sr1);
      p20 <= -sp1;
      p21 <= mul20(cp1, sr1); p22 <= mul20(cp1, cr1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= to_q14(24'(p00));
      m[1] <= to_q14(24'(p01a) - 24'(p01b));
      m[2] <= to_q14(24'(p02a) + 24'(p02b));
      m[3] <= to_q14(24'(p10));
      m[4] <= to_q14(24'(p11a) + 24'(p11b));
      m[5] <= to_q14(24'(p12a) - 24'(p12b));
      m[6] <= to_q14(24'(p20));
      m[7] <= to_q14(24'(p21));
      m[8] <= to_q14(24'(p22));
    end
  end
endmodule
`default_nettype wire

[sv/euler_to_rotation_matrix_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Euler ZYX pose to rotation matrix.
// The pose channel (sink) carries a position and roll, pitch and yaw angles
// in radians scaled by 8192; the result channel (source) carries the nine
// Q2.14 entries of Rz(yaw)*Ry(pitch)*Rx(roll) and the position unchanged.
// A transaction on each side completes when valid and ready are both high.
// The pipeline is one range-fold stage, one stage per CORDIC iteration, one
// rounding stage and three product/sum stages of the matrix pipeline.
// Throughput is one transaction per cycle unless the receiver stalls.
// The whole pipeline advances as one; when the receiver stalls
// with the output register full, every stage holds and pose ready drops,
// so nothing is lost or repeated. An empty output register lets the
// pipeline advance regardless of the receiver.
// A synchronous reset clears the valid bits; payload registers are not reset.
// No state is kept between poses.
module euler_to_rotation_matrix_core (
  input wire logic clk,
  input wire logic rst,
  e2r_if.sink   pose,
  e2r_if.source rot
);
  import e2r_pkg::*;

  localparam int Lat = UsedStages + 5;

  logic [Lat-1:0] vld;
  logic en;
  q20_t sr, cr, sp, cp, sy, cy;
  word_t m [9];
  word_t px [Lat], py [Lat], pz [Lat];

  // Stall only when the last stage holds a result that is not being taken.
  assign en = !vld[Lat-1] || rot.ready;
  assign pose.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], pose.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= pose.data.pos_x; py[0] <= pose.data.pos_y; pz[0] <= pose.data.pos_z;
      for (int i = 1; i < Lat; i++) begin
        px[i] <= px[i-1]; py[i] <= py[i-1]; pz[i] <= pz[i-1];
      end
    end
  end

  e2r_cordic u_roll  (.clk, .en, .angle(pose.data.roll_angle),  .sin_q(sr), .cos_q(cr));
  e2r_cordic u_pitch (.clk, .en, .angle(pose.data.pitch_angle), .sin_q(sp), .cos_q(cp));
  e2r_cordic u_yaw   (.clk, .en, .angle(pose.data.yaw_angle),   .sin_q(sy), .cos_q(cy));

  e2r_matrix u_mat (.clk, .en, .sr, .cr, .sp, .cp, .sy, .cy, .m);

  assign rot.valid = vld[Lat-1];
  assign rot.data = '{m00: m[0], m01: m[1], m02: m[2], m10: m[3], m11: m[4], m12: m[5],
                      m20: m[6], m21: m[7], m22: m[8],
                      out_x: px[Lat-1], out_y: py[Lat-1], out_z: pz[Lat-1]};
endmodule
`default_nettype wire
